FILE: hw/rtl/mcpm_pkg.sv
// Package with the shared types and constants of the molecule center block.
package mcpm_pkg;

  localparam int unsigned MAX_ATOMS_DEF = 256;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned BOX_W = 31;
  localparam logic signed [23:0] ONE_Q816 = 24'sd65536;
  localparam int unsigned DIV_ITER_W = 7;
  localparam logic [DIV_ITER_W-1:0] UNWRAP_ITERS = 7'd36;
  localparam logic [DIV_ITER_W-1:0] CENTER_ITERS = 7'd64;

  typedef enum logic [1:0] {
    MODE_NUMBER = 2'd0,
    MODE_CHARGE = 2'd1,
    MODE_MASS   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_BOX_X = 2'd1,
    REG_BOX_Y = 2'd2,
    REG_BOX_Z = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AXIS, ST_DIV_WAIT, ST_MUL, ST_ACC, ST_WT, ST_CTR, ST_CTR_WAIT, ST_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] weight;
    logic               last_atom;
  } atom_req_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic               zero_weight;
    logic [CNT_W-1:0]   atom_count;
  } center_rsp_t;

  // Classified atom handed from the front to the back.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] w;
    logic               last;
  } work_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [BOX_W-1:0] box_x;
    logic [BOX_W-1:0] box_y;
    logic [BOX_W-1:0] box_z;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [63:0]           dividend;
    logic [31:0]           divisor;
    logic [DIV_ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

FILE: hw/rtl/mcpm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module mcpm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcpm_pkg::div_req_t req_i,
  output mcpm_pkg::div_rsp_t rsp_o
);
  import mcpm_pkg::*;

  logic                  busy_q, busy_d, done_q, done_d;
  logic [DIV_ITER_W-1:0] cnt_q, cnt_d;
  logic [63:0]           quo_q, quo_d;
  logic [31:0]           rem_q, rem_d, dvs_q, dvs_d;
  logic [32:0]           trial;

  // One shift and trial subtract per cycle; the dividend arrives left aligned.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[63]} - {1'b0, dvs_q};
    if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: hw/rtl/mcpm_front.sv
// Front part: configuration registers, request intake, weight selection and queue.
module mcpm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [30:0]          cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  mcpm_pkg::atom_req_t  req_i,
  output mcpm_pkg::cfg_t       cfg_o,
  output logic                 work_valid_o,
  output mcpm_pkg::work_t      work_o,
  input  logic                 work_ack_i
);
  import mcpm_pkg::*;

  cfg_t              cfg_q, cfg_d;
  work_t             mem_q [QDEPTH];
  work_t             cls;
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  // Register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:  cfg_d.mode  = cfg_data_i[1:0];
        REG_BOX_X: cfg_d.box_x = cfg_data_i;
        REG_BOX_Y: cfg_d.box_y = cfg_data_i;
        REG_BOX_Z: cfg_d.box_z = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  // Classify: number mode replaces the weight by one.
  always_comb begin
    cls.pos_x = req_i.pos_x;
    cls.pos_y = req_i.pos_y;
    cls.pos_z = req_i.pos_z;
    cls.w     = (cfg_q.mode == MODE_NUMBER) ? ONE_Q816 : req_i.weight;
    cls.last  = req_i.last_atom;
  end

  // Queue pointers and fill count.
  assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = work_ack_i && (cnt_q != '0);
  assign work_valid_o = (cnt_q != '0);
  assign work_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_MASS;
      cfg_q.box_x <= '0;
      cfg_q.box_y <= '0;
      cfg_q.box_z <= '0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
    end else begin
      cfg_q  <= cfg_d;
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cls;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/mcpm_back.sv
// Back part: unwrapping, weighted accumulation, final division and result register.
module mcpm_back #(
  parameter int unsigned MAX_ATOMS = mcpm_pkg::MAX_ATOMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcpm_pkg::cfg_t        cfg_i,
  input  logic                  work_valid_i,
  input  mcpm_pkg::work_t       work_i,
  output logic                  work_ack_o,
  output mcpm_pkg::div_req_t    div_req_o,
  input  mcpm_pkg::div_rsp_t    div_rsp_i,
  output logic                  empty,
  input  logic                  pop,
  output mcpm_pkg::center_rsp_t rsp_o
);
  import mcpm_pkg::*;

  back_state_e        state_q, state_d;
  work_t              item_q, item_d;
  logic signed [31:0] ref_q [3];
  logic signed [31:0] ref_d [3];
  logic signed [63:0] sum_q [3];
  logic signed [63:0] sum_d [3];
  logic signed [31:0] ctr_q [3];
  logic signed [31:0] ctr_d [3];
  logic signed [31:0] wt_q, wt_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               first_q, first_d, zw_q, zw_d;
  logic [1:0]         axis_q, axis_d;
  logic signed [32:0] d_q, d_d;
  logic [35:0]        n_q, n_d;
  logic               dn_q, dn_d;
  logic signed [33:0] u_q, u_d;
  logic signed [57:0] prod_q, prod_d;
  logic               oval_q, oval_d;
  center_rsp_t        out_q, out_d;

  logic signed [31:0] p_sel, r_sel;
  logic [BOX_W-1:0]   b_sel;
  logic signed [32:0] d_c;
  logic signed [35:0] d2x, bx, d36, nb, dp, ux;
  logic signed [64:0] sum_x;
  logic signed [32:0] wt_x;
  logic [63:0]        ms;
  logic [31:0]        mw;
  logic               cneg;
  logic [63:0]        q;

  // Per-axis operand selection.
  always_comb begin
    unique case (axis_q)
      2'd0:    begin p_sel = item_q.pos_x; b_sel = cfg_i.box_x; end
      2'd1:    begin p_sel = item_q.pos_y; b_sel = cfg_i.box_y; end
      default: begin p_sel = item_q.pos_z; b_sel = cfg_i.box_z; end
    endcase
    r_sel = ref_q[axis_q];
  end

  // Offset from the reference and the unwrap arithmetic.
  always_comb begin
    d_c  = {p_sel[31], p_sel} - {r_sel[31], r_sel};
    d2x  = {{2{d_c[32]}}, d_c, 1'b0};
    bx   = {5'b0, b_sel};
    d36  = {{3{d_q[32]}}, d_q};
    nb   = $signed((n_q - {4'b0, div_rsp_i.remainder}) >> 1);
    dp   = dn_q ? d36 - nb : d36 + nb;
    ux   = {{4{r_sel[31]}}, r_sel} + dp;
    sum_x = {sum_q[axis_q][63], sum_q[axis_q]} + {{7{prod_q[57]}}, prod_q};
    wt_x = {wt_q[31], wt_q} + {{9{item_q.w[23]}}, item_q.w};
    ms   = sum_q[axis_q][63] ? 64'(-sum_q[axis_q]) : 64'(sum_q[axis_q]);
    mw   = wt_q[31] ? 32'(-wt_q) : 32'(wt_q);
    cneg = sum_q[axis_q][63] ^ wt_q[31];
    q    = div_rsp_i.quotient;
    prod_d = u_q * item_q.w;
  end

  // Sequencer for one atom and, on the last atom, the three divisions.
  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    ref_d   = ref_q;
    sum_d   = sum_q;
    ctr_d   = ctr_q;
    wt_d    = wt_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    zw_d    = zw_q;
    axis_d  = axis_q;
    d_d     = d_q;
    n_d     = n_q;
    dn_d    = dn_q;
    u_d     = u_q;
    out_d   = out_q;
    oval_d  = oval_q && !pop;
    work_ack_o = 1'b0;
    div_req_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (work_valid_i) begin
          work_ack_o = 1'b1;
          item_d = work_i;
          if (first_q) begin
            ref_d[0] = work_i.pos_x;
            ref_d[1] = work_i.pos_y;
            ref_d[2] = work_i.pos_z;
            first_d  = 1'b0;
          end
          axis_d  = 2'd0;
          state_d = ST_AXIS;
        end
      end
      ST_AXIS: begin
        d_d = d_c;
        if (b_sel != '0 && d2x > bx) begin
          n_d  = 36'(d2x + bx - 36'sd1);
          dn_d = 1'b1;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {36'(d2x + bx - 36'sd1), 28'b0};
          div_req_o.divisor  = {b_sel, 1'b0};
          div_req_o.iters    = UNWRAP_ITERS;
          state_d = ST_DIV_WAIT;
        end else if (b_sel != '0 && d2x < -bx) begin
          n_d  = 36'(-d2x + bx - 36'sd1);
          dn_d = 1'b0;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {36'(-d2x + bx - 36'sd1), 28'b0};
          div_req_o.divisor  = {b_sel, 1'b0};
          div_req_o.iters    = UNWRAP_ITERS;
          state_d = ST_DIV_WAIT;
        end else begin
          u_d     = 34'(p_sel);
          state_d = ST_MUL;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          u_d     = ux[33:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (sum_x[64] != sum_x[63]) begin
          sum_d[axis_q] = sum_x[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
          sum_d[axis_q] = sum_x[63:0];
        end
        if (axis_q == 2'd2) begin
          state_d = ST_WT;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_AXIS;
        end
      end
      ST_WT: begin
        if (wt_x[32] != wt_x[31]) begin
          wt_d = wt_x[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end else begin
          wt_d = wt_x[31:0];
        end
        if (cnt_q < CNT_W'(MAX_ATOMS)) begin
          cnt_d = cnt_q + 1'b1;
        end
        axis_d  = 2'd0;
        state_d = item_q.last ? ST_CTR : ST_IDLE;
      end
      ST_CTR: begin
        if (wt_q == '0) begin
          ctr_d[0] = '0;
          ctr_d[1] = '0;
          ctr_d[2] = '0;
          zw_d     = 1'b1;
          state_d  = ST_OUT;
        end else begin
          zw_d = 1'b0;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = ms + {33'b0, mw[31:1]};
          div_req_o.divisor  = mw;
          div_req_o.iters    = CENTER_ITERS;
          state_d = ST_CTR_WAIT;
        end
      end
      ST_CTR_WAIT: begin
        if (div_rsp_i.done) begin
          if (cneg) begin
            ctr_d[axis_q] = (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
          end else begin
            ctr_d[axis_q] = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
          end
          if (axis_q == 2'd2) begin
            state_d = ST_OUT;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = ST_CTR;
          end
        end
      end
      ST_OUT: begin
        // Hand the result over once the output register is free.
        if (!oval_q) begin
          oval_d            = 1'b1;
          out_d.center_x    = ctr_q[0];
          out_d.center_y    = ctr_q[1];
          out_d.center_z    = ctr_q[2];
          out_d.zero_weight = zw_q;
          out_d.atom_count  = cnt_q;
          ref_d[0] = '0;
          ref_d[1] = '0;
          ref_d[2] = '0;
          sum_d[0] = '0;
          sum_d[1] = '0;
          sum_d[2] = '0;
          wt_d     = '0;
          cnt_d    = '0;
          first_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ref_q   <= '{default: '0};
      sum_q   <= '{default: '0};
      wt_q    <= '0;
      cnt_q   <= '0;
      first_q <= 1'b1;
      axis_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ref_q   <= ref_d;
      sum_q   <= sum_d;
      wt_q    <= wt_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      axis_q  <= axis_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ctr_q  <= ctr_d;
    zw_q   <= zw_d;
    d_q    <= d_d;
    n_q    <= n_d;
    dn_q   <= dn_d;
    u_q    <= u_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign empty = !oval_q;
  assign rsp_o = out_q;

endmodule

FILE: hw/rtl/molecule_center_periodic_modes.sv
// Top level of the weighted molecule center block with periodic unwrapping.
// Per atom: an intake step, then per axis the unwrap, multiply and accumulate steps, with a division
// for each axis that wraps (the shared bit-serial divider takes one quotient bit per cycle), then a weight step.
// On the last atom, a center division per axis, then the hand-over to the result register.
// A two-entry queue takes requests while the back part works; one result register.
// Reset (asynchronous, active low) clears all molecule state; no clearing pass.
module molecule_center_periodic_modes #(
  parameter int unsigned MAX_ATOMS = mcpm_pkg::MAX_ATOMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [30:0]           cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  mcpm_pkg::atom_req_t   req_i,
  output logic                  empty,
  input  logic                  pop,
  output mcpm_pkg::center_rsp_t rsp_o
);
  import mcpm_pkg::*;

  cfg_t     cfg;
  logic     work_valid, work_ack;
  work_t    work;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mcpm_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .req_i,
    .cfg_o(cfg), .work_valid_o(work_valid), .work_o(work), .work_ack_i(work_ack)
  );

  mcpm_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  mcpm_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .work_valid_i(work_valid), .work_i(work), .work_ack_o(work_ack),
    .div_req_o(div_req), .div_rsp_i(div_rsp),
    .empty, .pop, .rsp_o
  );

`ifndef SYNTHESIS
  a_zero_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.zero_weight) |->
    (rsp_o.center_x == 0 && rsp_o.center_y == 0 && rsp_o.center_z == 0))
    else $error("zero weight result with nonzero center");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (rsp_o.atom_count != 0 && rsp_o.atom_count <= CNT_W'(MAX_ATOMS)))
    else $error("atom count out of range");
  a_ack_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_ack |-> work_valid)
    else $error("back part took an item from an empty queue");
`endif

endmodule

FILE: test/mcpm_center_checker.sv
// Checker that predicts molecule centers from observed atom requests and compares results.
`timescale 1ns / 1ps
module mcpm_center_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [30:0]           cfg_data_i,
  input  logic                  push_i,
  input  logic                  full_i,
  input  mcpm_pkg::atom_req_t   req_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  mcpm_pkg::center_rsp_t rsp_i,
  output int                    centers_pending_o,
  output int                    fail_count_o
);
  import mcpm_pkg::*;

  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

  // Shadow configuration and molecule accumulation state.
  logic [1:0]       mode_q;
  logic [BOX_W-1:0] box_q [3];
  longint           ref_q [3];
  longint           sum_q [3];
  longint           wsum_q;
  int               atoms_q;
  logic             first_q;
  center_rsp_t      center_queue [$];

  assign centers_pending_o = center_queue.size();

  // Move p by whole box lengths until it lies within half a box of r.
  function automatic longint unwrap_axis(longint p, longint r, logic [BOX_W-1:0] box);
    longint d;
    longint b;
    longint n;
    d = p - r;
    b = longint'(box);
    if (b != 0) begin
      if (2 * d > b) begin
        n = (2 * d + b - 1) / (2 * b);
        d = d - n * b;
      end else if (2 * d < -b) begin
        n = (-2 * d + b - 1) / (2 * b);
        d = d + n * b;
      end
    end
    return r + d;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > I64_MAX - b) return I64_MAX;
    if (b < 0 && a < I64_MIN - b) return I64_MIN;
    return a + b;
  endfunction

  // Rounded quotient, ties away from zero, saturated to 32 bits.
  function automatic logic signed [31:0] center_axis(longint s, longint w);
    logic [63:0] ms;
    logic [63:0] mw;
    logic [63:0] q;
    ms = (s < 0) ? 64'd0 - 64'(s) : 64'(s);
    mw = (w < 0) ? 64'd0 - 64'(w) : 64'(w);
    q  = (ms + mw / 2) / mw;
    if ((s < 0) != (w < 0)) begin
      return (q > 64'd2147483648) ? 32'sh8000_0000 : 32'(64'd0 - q);
    end
    return (q > 64'd2147483647) ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    longint      pos [3];
    longint      w;
    center_rsp_t c;
    center_rsp_t got;
    if (!rst_ni) begin
      mode_q   <= MODE_MASS;
      box_q    <= '{default: '0};
      ref_q    = '{default: 0};
      sum_q    = '{default: 0};
      wsum_q   = 0;
      atoms_q  = 0;
      first_q  = 1'b1;
      fail_count_o <= 0;
      center_queue.delete();
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MODE:  mode_q   <= cfg_data_i[1:0];
          REG_BOX_X: box_q[0] <= cfg_data_i;
          REG_BOX_Y: box_q[1] <= cfg_data_i;
          REG_BOX_Z: box_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      // Accepted atom request.
      if (push_i && !full_i) begin
        pos[0] = longint'(req_i.pos_x);
        pos[1] = longint'(req_i.pos_y);
        pos[2] = longint'(req_i.pos_z);
        w = (mode_q == MODE_NUMBER) ? longint'(ONE_Q816) : longint'(req_i.weight);
        for (int a = 0; a < 3; a++) begin
          if (first_q) ref_q[a] = pos[a];
          sum_q[a] = sat_sum(sum_q[a], unwrap_axis(pos[a], ref_q[a], box_q[a]) * w);
        end
        wsum_q = wsum_q + w;
        if (wsum_q > 64'sd2147483647) wsum_q = 64'sd2147483647;
        if (wsum_q < -64'sd2147483648) wsum_q = -64'sd2147483648;
        if (atoms_q < 256) atoms_q = atoms_q + 1;
        first_q = 1'b0;
        if (req_i.last_atom) begin
          c.zero_weight = (wsum_q == 0);
          c.center_x = c.zero_weight ? '0 : center_axis(sum_q[0], wsum_q);
          c.center_y = c.zero_weight ? '0 : center_axis(sum_q[1], wsum_q);
          c.center_z = c.zero_weight ? '0 : center_axis(sum_q[2], wsum_q);
          c.atom_count = atoms_q[CNT_W-1:0];
          center_queue.push_back(c);
          ref_q   = '{default: 0};
          sum_q   = '{default: 0};
          wsum_q  = 0;
          atoms_q = 0;
          first_q = 1'b1;
        end
      end
      // Accepted result.
      if (pop_i && !empty_i) begin
        got = rsp_i;
        if (center_queue.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected center result %p", got);
        end else begin
          c = center_queue.pop_front();
          if (got.center_x !== c.center_x || got.center_y !== c.center_y ||
              got.center_z !== c.center_z || got.zero_weight !== c.zero_weight ||
              got.atom_count !== c.atom_count) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) begin
              $display("center mismatch: expected x=%0d y=%0d z=%0d zw=%0d n=%0d",
                       c.center_x, c.center_y, c.center_z, c.zero_weight, c.atom_count);
              $display("                 actual   x=%0d y=%0d z=%0d zw=%0d n=%0d",
                       got.center_x, got.center_y, got.center_z, got.zero_weight,
                       got.atom_count);
            end
          end
        end
      end
    end
  end
endmodule

FILE: test/molecule_center_periodic_modes_tb.sv
// Testbench top: atom stimulus, result draining, configuration phases and verdict.
`timescale 1ns / 1ps
module molecule_center_periodic_modes_tb;
  import mcpm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 500;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [30:0] BOX_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] BOX_TEN = 31'd655360;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [30:0] cfg_data;
  logic        push;
  logic        full;
  atom_req_t   req;
  logic        empty;
  logic        pop;
  center_rsp_t rsp;
  int          centers_pending;
  int          fail_count;
  int          cycles = 0;
  int          pop_hold;
  int          atoms_sent;
  logic [30:0] box_now [3];

  molecule_center_periodic_modes u_top (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .push(push), .full(full), .req_i(req),
    .empty(empty), .pop(pop), .rsp_o(rsp)
  );

  mcpm_center_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .push_i(push), .full_i(full), .req_i(req),
    .empty_i(empty), .pop_i(pop), .rsp_i(rsp),
    .centers_pending_o(centers_pending), .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: pop with random stalls, mostly short and a few long.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2: pop_hold <= $urandom_range(1, 3);
        3:       pop_hold <= $urandom_range(20, 80);
        default: pop_hold <= 0;
      endcase
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [30:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx != REG_MODE) box_now[idx - 1] = data;
  endtask

  // Wait for every expected center, then for any atom still in flight.
  task automatic drain();
    push <= 1'b0;
    while (centers_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send one atom request after a random gap; push stays high across back-to-back requests.
  task automatic send_atom(input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic signed [31:0] z, input logic signed [23:0] w,
                           input logic last);
    int gap;
    case ($urandom_range(0, 9))
      0, 1:    gap = $urandom_range(1, 4);
      2:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150) : 0;
      default: gap = 0;
    endcase
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    req  <= '{pos_x: x, pos_y: y, pos_z: z, weight: w, last_atom: last};
    do @(negedge clk); while (full);
    @(posedge clk);
    atoms_sent++;
  endtask

  // Position near a reference, often several boxes away, sometimes anywhere.
  function automatic logic signed [31:0] near_pos(logic signed [31:0] base, int axis);
    longint span;
    span = (box_now[axis] == 0) ? 64'd1 << 20 : longint'(box_now[axis]);
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return base + 32'(box_now[axis] >> 1);
      2:       return base - 32'(box_now[axis] >> 1);
      3:       return base + $signed(32'($urandom_range(0, 8))) * 32'(span)
                      - 32'(span * 4) + $signed(32'($urandom_range(0, 4095))) - 2048;
      default: return base + $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
    endcase
  endfunction

  function automatic logic signed [23:0] rand_weight();
    case ($urandom_range(0, 5))
      0:       return 24'($urandom);
      1:       return 24'sd0;
      2:       return -$signed(24'($urandom_range(1, 40 << 16)));
      default: return 24'($urandom_range(1, 40 << 16));
    endcase
  endfunction

  task automatic random_molecule(input int n_atoms);
    logic signed [31:0] rx, ry, rz;
    rx = $urandom;
    ry = $urandom;
    rz = $urandom;
    for (int i = 0; i < n_atoms; i++) begin
      if (i == 0) send_atom(rx, ry, rz, rand_weight(), n_atoms == 1);
      else send_atom(near_pos(rx, 0), near_pos(ry, 1), near_pos(rz, 2), rand_weight(),
                     i == n_atoms - 1);
    end
  endtask

  task automatic random_config();
    logic [30:0] b;
    write_reg(REG_MODE, 31'($urandom_range(0, 3)));
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 5))
        0:       b = '0;
        1:       b = BOX_MAX;
        2:       b = 31'd1;
        3:       b = 31'($urandom);
        default: b = 31'($urandom_range(1 << 16, 40 << 16));
      endcase
      write_reg(cfg_reg_e'(a + 1), b);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_MODE;
    cfg_data = '0;
    push     = 1'b0;
    req      = '0;
    atoms_sent = 0;
    box_now  = '{default: '0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: box 10 nm on x, no wrap on y, largest box on z.
    write_reg(REG_MODE, 31'(MODE_MASS));
    write_reg(REG_BOX_X, BOX_TEN);
    write_reg(REG_BOX_Y, '0);
    write_reg(REG_BOX_Z, BOX_MAX);
    // Single-atom molecules at the field extremes.
    send_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'sh7F_FFFF, 1'b1);
    send_atom(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'sh80_0000, 1'b1);
    // Offsets of exactly plus and minus half a box, and far offsets.
    send_atom(32'sd0, 32'sd0, 32'sd0, 24'sd65536, 1'b0);
    send_atom(32'sd327680, 32'sd327680, 32'sh4000_0000, 24'sd65536, 1'b0);
    send_atom(-32'sd327680, -32'sd327680, -32'sh4000_0000, 24'sd65536, 1'b0);
    send_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'sd65536, 1'b1);
    // Zero total weight.
    send_atom(32'sd1000, 32'sd2000, 32'sd3000, 24'sd98304, 1'b0);
    send_atom(32'sd1500, 32'sd2500, 32'sd3500, -24'sd98304, 1'b1);
    // Positions near the 32-bit limits with a negative weight, then with the largest weight.
    send_atom(32'sh7FFF_0000, 32'sh8001_0000, 32'sh7FFF_0000, 24'sd2, 1'b0);
    send_atom(32'sh7FFF_0000, 32'sh8001_0000, 32'sh7FFF_0000, -24'sd1, 1'b1);
    send_atom(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'sh7F_FFFF, 1'b0);
    send_atom(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'sh7F_FFFF, 1'b1);
    // Number, charge and the unused mode.
    drain();
    write_reg(REG_MODE, 31'(MODE_NUMBER));
    send_atom(32'sd65536, 32'sd5, 32'sd7, 24'sh80_0000, 1'b0);
    send_atom(32'sd131072, 32'sd6, 32'sd8, 24'sd0, 1'b1);
    drain();
    write_reg(REG_MODE, 31'(MODE_CHARGE));
    send_atom(32'sd100, 32'sd200, 32'sd300, -24'sd65536, 1'b0);
    send_atom(32'sd101, 32'sd201, 32'sd301, 24'sd32768, 1'b1);
    drain();
    write_reg(REG_MODE, 31'(MODE_UNUSED));
    send_atom(32'sd655360, 32'sd0, 32'sd0, 24'sd131072, 1'b1);
    // Mode changed in the middle of a molecule.
    send_atom(32'sd10, 32'sd20, 32'sd30, 24'sd200000, 1'b0);
    drain();
    write_reg(REG_MODE, 31'(MODE_NUMBER));
    send_atom(32'sd50, 32'sd60, 32'sd70, 24'sd5, 1'b1);
    drain();

    // Random phases, with one molecule longer than the atom counter.
    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      if (phase == 4) random_molecule(260);
      for (int m = 0; m < 22; m++) begin
        random_molecule(($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) :
                        $urandom_range(1, 4));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
